FILE: rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// Cubic Hermite spline evaluator package
// Shared word types, saturation limits and command and status codes.
// ----------------------------------------------------------------------------
package chs_pkg;

    // Q16.16 data word and the wide internal accumulator.
    typedef logic signed [31:0] t_word;
    typedef logic signed [63:0] t_acc;

    // Accumulator saturation limits.
    localparam t_acc SAT64     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_acc NEG_SAT64 = -64'sh7FFF_FFFF_FFFF_FFFF;

    // Result range of the final value.
    localparam t_acc WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam t_acc WORD_MIN = -64'sh0000_0000_8000_0000;

    // Commands.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_INSIDE = 2'd0;
    localparam logic [1:0] ST_EXTRAP = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

endpackage

FILE: rtl/chs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, registered read, read before write.
// ----------------------------------------------------------------------------
module chs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Storage and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: rtl/chs_mulq.sv
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Five-stage 64 by 64 product built from 32 by 32 partial products, rounded
// to nearest with ties away from zero and saturated, with a side band.
// ----------------------------------------------------------------------------
module chs_mulq #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  chs_pkg::t_acc       i_a,
    input  chs_pkg::t_acc       i_b,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output chs_pkg::t_acc       o_p,
    output logic                o_sat,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] r_valid;
    logic [SIDE_W-1:0] r_side [STAGES];

    logic               r1_neg;
    logic [63:0]        r1_ua;
    logic [63:0]        r1_ub;
    logic               r2_neg;
    logic [63:0]        r2_p0;
    logic [63:0]        r2_p1;
    logic [63:0]        r2_p2;
    logic [63:0]        r2_p3;
    logic               r3_neg;
    logic [127:0]       r3_full;
    logic               r4_neg;
    logic [127:0]       r4_rnd;
    chs_pkg::t_acc      r5_p;
    logic               r5_sat;

    logic [127:0]       w_shift;
    logic               w_sat;
    logic [63:0]        w_mag;

    // Rescale and detect overflow; the sign is restored in the last stage.
    always_comb begin
        w_shift = r4_rnd >> FRAC_BITS;
        w_sat   = |w_shift[127:63];
        w_mag   = w_sat ? 64'(chs_pkg::SAT64) : {1'b0, w_shift[62:0]};
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[STAGES-2:0], i_valid};
        end
    end

    // Data path stages.
    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int k = 1; k < STAGES; k++) begin
            r_side[k] <= r_side[k-1];
        end
        r1_neg  <= i_a[63] ^ i_b[63];
        r1_ua   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
        r1_ub   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
        r2_neg  <= r1_neg;
        r2_p0   <= 64'(r1_ua[31:0])  * 64'(r1_ub[31:0]);
        r2_p1   <= 64'(r1_ua[31:0])  * 64'(r1_ub[63:32]);
        r2_p2   <= 64'(r1_ua[63:32]) * 64'(r1_ub[31:0]);
        r2_p3   <= 64'(r1_ua[63:32]) * 64'(r1_ub[63:32]);
        r3_neg  <= r2_neg;
        r3_full <= 128'(r2_p0) + (128'(r2_p1) << 32) + (128'(r2_p2) << 32)
                   + (128'(r2_p3) << 64);
        r4_neg  <= r3_neg;
        r4_rnd  <= r3_full + (128'd1 << (FRAC_BITS - 1));
        r5_sat  <= w_sat;
        r5_p    <= r4_neg ? -chs_pkg::t_acc'(w_mag) : chs_pkg::t_acc'(w_mag);
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_p     = r5_p;
    assign o_sat   = r5_sat;
    assign o_side  = r_side[STAGES-1];

endmodule

FILE: rtl/chs_div.sv
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Computes round(num * 2^FRAC_BITS / den), ties away from zero, one
// quotient bit per stage, with a side band.
// ----------------------------------------------------------------------------
module chs_div #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [32:0]          i_num,
    input  logic signed [32:0]          i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic signed [33+FRAC_BITS:0] o_quot,
    output logic [SIDE_W-1:0]           o_side
);

    // Numerator bits, equal to the number of iterations.
    localparam int NW = 33 + FRAC_BITS;

    logic              r_valid [NW+2];
    logic [SIDE_W-1:0] r_side  [NW+2];
    logic              r_neg   [NW+1];
    logic [31:0]       r_den   [NW+1];
    logic [31:0]       r_rem   [NW+1];
    logic [NW-1:0]     r_num   [NW+1];
    logic signed [NW:0] r_quot;

    logic [31:0]       n_rem   [NW];
    logic [NW-1:0]     n_num   [NW];
    logic [32:0]       w_un;
    logic [32:0]       w_ud;

    assign w_un = i_num[32] ? 33'(-i_num) : 33'(i_num);
    assign w_ud = i_den[32] ? 33'(-i_den) : 33'(i_den);

    // One restoring step per stage; the quotient shifts in behind the numerator.
    always_comb begin
        for (int k = 0; k < NW; k++) begin
            logic [32:0] trial;
            logic        ge;
            trial    = {r_rem[k], r_num[k][NW-1]};
            ge       = trial >= {1'b0, r_den[k]};
            n_rem[k] = ge ? 32'(trial - {1'b0, r_den[k]}) : trial[31:0];
            n_num[k] = {r_num[k][NW-2:0], ge};
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW + 2; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < NW + 2; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    // Operand preparation, iterations and sign restore.
    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        r_neg[0]  <= i_num[32] ^ i_den[32];
        r_den[0]  <= w_ud[31:0];
        r_rem[0]  <= '0;
        r_num[0]  <= (NW'(w_un[31:0]) << FRAC_BITS) + NW'(w_ud[32:1]);
        for (int k = 0; k < NW; k++) begin
            r_side[k+1] <= r_side[k];
            r_neg[k+1]  <= r_neg[k];
            r_den[k+1]  <= r_den[k];
            r_rem[k+1]  <= n_rem[k];
            r_num[k+1]  <= n_num[k];
        end
        r_side[NW+1] <= r_side[NW];
        r_quot <= r_neg[NW] ? -$signed({1'b0, r_num[NW]}) : $signed({1'b0, r_num[NW]});
    end

    assign o_valid = r_valid[NW+1];
    assign o_quot  = r_quot;
    assign o_side  = r_side[NW+1];

endmodule

FILE: rtl/cubic_hermite_spline_eval_unit.sv
// ----------------------------------------------------------------------------
// Cubic Hermite spline evaluation unit
// Holds a knot table and evaluates the piecewise cubic Hermite spline at a
// sample position, one sample per cycle.
// ----------------------------------------------------------------------------
//  Channel   Signals                                         Direction
//  command   start, busy (out), i_cmd, i_knot_index,           in
//            i_position, i_knot_value, i_knot_slope
//  result    o_valid, o_curve_value, o_status                out
//  config    i_cfg_we, i_cfg_wdata (knot count)              in
//
// A command transfers when start is high and busy is low; busy stays low, so
// one command can transfer in every cycle. A load writes the table at once and
// gives no result. An evaluate passes the compare, table read and difference
// stages, the one-bit-per-stage divider, the slope and Horner multipliers of
// five stages each and the output register. Reset clears the valid bits and
// sets the knot count to two; the table holds no defined data until written.
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module cubic_hermite_spline_eval_unit #(
    parameter int MAX_KNOTS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cmd,
    input  logic [3:0]          i_knot_index,
    input  logic signed [31:0]  i_position,
    input  logic signed [31:0]  i_knot_value,
    input  logic signed [31:0]  i_knot_slope,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_wdata,
    output logic                o_valid,
    output logic signed [31:0]  o_curve_value,
    output logic [1:0]          o_status
);

    localparam int IW = $clog2(MAX_KNOTS);
    localparam int CW = $clog2(MAX_KNOTS + 1);
    localparam int QW = 34 + FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] y0;
        logic signed [32:0] dy;
        logic signed [31:0] m0;
        logic signed [31:0] m1;
        logic signed [32:0] h;
        logic               ext;
        logic               hz;
    } t_div_side;

    typedef struct packed {
        logic signed [63:0] t;
        logic signed [31:0] y0;
        logic               ext;
        logic               hz;
    } t_hm0_side;

    typedef struct packed {
        logic signed [32:0] dy;
    } t_hm1_side;

    typedef struct packed {
        logic signed [63:0] a2;
        logic signed [63:0] hm0;
        logic signed [31:0] y0;
        logic signed [63:0] t;
        logic               sat;
        logic               ext;
        logic               hz;
    } t_h1_side;

    typedef struct packed {
        logic signed [63:0] hm0;
        logic signed [31:0] y0;
        logic signed [63:0] t;
        logic               sat;
        logic               ext;
        logic               hz;
    } t_h2_side;

    typedef struct packed {
        logic signed [31:0] y0;
        logic               sat;
        logic               ext;
        logic               hz;
    } t_h3_side;

    // Configuration and knot positions for the interval search.
    logic [4:0]          r_cnt;
    chs_pkg::t_word      r_pos [MAX_KNOTS];
    logic [CW-1:0]       w_n;
    logic [IW-1:0]       w_last;
    logic                w_accept;
    logic                w_load;
    logic [IW-1:0]       w_load_idx;

    // Compare stage.
    logic                r_s1_valid;
    chs_pkg::t_word      r_s1_x;
    logic                r_s1_lt0;
    logic [MAX_KNOTS-1:1] r_s1_le;
    logic [MAX_KNOTS-1:0] r_s1_gt;
    logic [IW-1:0]       w_seg;

    // Table read stage.
    logic                r_s2_valid;
    chs_pkg::t_word      r_s2_x;
    logic                r_s2_ext;
    logic [95:0]         w_knot_a;
    logic [95:0]         w_knot_b;

    // Difference stage.
    logic                r_s3_valid;
    logic signed [32:0]  r_s3_h;
    logic signed [32:0]  r_s3_d;
    t_div_side           r_s3_side;

    // Divider outputs.
    logic                w_div_valid;
    logic signed [QW-1:0] w_div_t;
    t_div_side           w_div_side;
    t_hm0_side           w_hm0_side_in;
    t_hm1_side           w_hm1_side_in;

    // Slope products.
    logic                w_hm_valid;
    logic                w_hm1_valid;
    chs_pkg::t_acc       w_hm0;
    chs_pkg::t_acc       w_hm1;
    logic                w_hm0_sat;
    logic                w_hm1_sat;
    t_hm0_side           w_hm0_side;
    t_hm1_side           w_hm1_side;

    // Coefficient stage.
    logic                r_c_valid;
    chs_pkg::t_acc       r_c_a3;
    t_h1_side            r_c_side;
    chs_pkg::t_acc       w_dy64;

    // Horner steps.
    logic                w_h1_valid;
    chs_pkg::t_acc       w_h1_p;
    logic                w_h1_sat;
    t_h1_side            w_h1_side;
    logic                r_a1_valid;
    chs_pkg::t_acc       r_a1_acc;
    t_h2_side            r_a1_side;

    logic                w_h2_valid;
    chs_pkg::t_acc       w_h2_p;
    logic                w_h2_sat;
    t_h2_side            w_h2_side;
    logic                r_a2_valid;
    chs_pkg::t_acc       r_a2_acc;
    t_h3_side            r_a2_side;
    chs_pkg::t_acc       r_a2_t;

    logic                w_h3_valid;
    chs_pkg::t_acc       w_h3_p;
    logic                w_h3_sat;
    t_h3_side            w_h3_side;
    logic                r_a3_valid;
    chs_pkg::t_acc       r_a3_acc;
    t_h3_side            r_a3_side;

    // Output register.
    logic                r_out_valid;
    chs_pkg::t_word      r_out_value;
    logic [1:0]          r_out_status;

    logic signed [64:0]  w_sum1;
    logic signed [64:0]  w_sum2;
    logic signed [64:0]  w_sum3;

    assign busy       = 1'b0;
    assign w_accept   = start && !busy;
    assign w_load     = w_accept && (i_cmd == chs_pkg::CMD_LOAD)
                        && (int'(i_knot_index) < MAX_KNOTS);
    assign w_load_idx = IW'(i_knot_index);

    // Effective knot count, clamped to between two and the table size.
    always_comb begin
        if (r_cnt < 5'd2) begin
            w_n = CW'(2);
        end else if (int'(r_cnt) > MAX_KNOTS) begin
            w_n = CW'(MAX_KNOTS);
        end else begin
            w_n = CW'(r_cnt);
        end
        w_last = IW'(int'(w_n) - 1);
    end

    // Interval choice: the first right knot at or above the sample.
    always_comb begin
        w_seg = IW'(int'(w_n) - 2);
        for (int i = MAX_KNOTS - 2; i >= 0; i--) begin
            if ((i < int'(w_n) - 1) && r_s1_le[i+1]) begin
                w_seg = IW'(i);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 5'd2;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_c_valid   <= 1'b0;
            r_a1_valid  <= 1'b0;
            r_a2_valid  <= 1'b0;
            r_a3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cnt <= i_cfg_wdata;
            end
            r_s1_valid  <= w_accept && (i_cmd == chs_pkg::CMD_EVAL);
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_c_valid   <= w_hm_valid && w_hm1_valid;
            r_a1_valid  <= w_h1_valid;
            r_a2_valid  <= w_h2_valid;
            r_a3_valid  <= w_h3_valid;
            r_out_valid <= r_a3_valid;
        end
    end

    // Knot positions and the compare stage.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pos[w_load_idx] <= i_position;
        end
        r_s1_x   <= i_position;
        r_s1_lt0 <= i_position < r_pos[0];
        for (int i = 0; i < MAX_KNOTS; i++) begin
            r_s1_gt[i] <= i_position > r_pos[i];
        end
        for (int i = 1; i < MAX_KNOTS; i++) begin
            r_s1_le[i] <= i_position <= r_pos[i];
        end
    end

    // Knot table: position, value and slope of each knot.
    chs_ram #(
        .WIDTH (96),
        .DEPTH (MAX_KNOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_load),
        .i_waddr   (w_load_idx),
        .i_wdata   ({i_position, i_knot_value, i_knot_slope}),
        .i_raddr_a (w_seg),
        .i_raddr_b (IW'(w_seg + IW'(1))),
        .o_rdata_a (w_knot_a),
        .o_rdata_b (w_knot_b)
    );

    // Table read stage and interval differences.
    always_ff @(posedge i_clk) begin
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] y0;
        logic signed [31:0] y1;
        logic signed [32:0] h;
        x0 = w_knot_a[95:64];
        x1 = w_knot_b[95:64];
        y0 = w_knot_a[63:32];
        y1 = w_knot_b[63:32];
        h  = 33'(x1) - 33'(x0);
        r_s2_x         <= r_s1_x;
        r_s2_ext       <= r_s1_lt0 || r_s1_gt[w_last];
        r_s3_h         <= h;
        r_s3_d         <= 33'(r_s2_x) - 33'(x0);
        r_s3_side.y0   <= y0;
        r_s3_side.dy   <= 33'(y1) - 33'(y0);
        r_s3_side.m0   <= w_knot_a[31:0];
        r_s3_side.m1   <= w_knot_b[31:0];
        r_s3_side.h    <= h;
        r_s3_side.ext  <= r_s2_ext;
        r_s3_side.hz   <= (h == 33'sd0);
    end

    // Local parameter t of the sample within its interval.
    chs_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(t_div_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_valid),
        .i_num   (r_s3_d),
        .i_den   (r_s3_h),
        .i_side  (r_s3_side),
        .o_valid (w_div_valid),
        .o_quot  (w_div_t),
        .o_side  (w_div_side)
    );

    assign w_hm0_side_in.t   = 64'(w_div_t);
    assign w_hm0_side_in.y0  = w_div_side.y0;
    assign w_hm0_side_in.ext = w_div_side.ext;
    assign w_hm0_side_in.hz  = w_div_side.hz;
    assign w_hm1_side_in.dy  = w_div_side.dy;

    // Slopes scaled by the interval width.
    chs_mulq #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(t_hm0_side))
    ) u_hm0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .i_a     (64'(w_div_side.h)),
        .i_b     (64'(w_div_side.m0)),
        .i_side  (w_hm0_side_in),
        .o_valid (w_hm_valid),
        .o_p     (w_hm0),
        .o_sat   (w_hm0_sat),
        .o_side  (w_hm0_side)
    );

    chs_mulq #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(t_hm1_side))
    ) u_hm1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .i_a     (64'(w_div_side.h)),
        .i_b     (64'(w_div_side.m1)),
        .i_side  (w_hm1_side_in),
        .o_valid (w_hm1_valid),
        .o_p     (w_hm1),
        .o_sat   (w_hm1_sat),
        .o_side  (w_hm1_side)
    );

    assign w_dy64 = 64'(w_hm1_side.dy);

    // Cubic coefficients.
    always_ff @(posedge i_clk) begin
        r_c_a3         <= (w_hm0 + w_hm1) - (w_dy64 <<< 1);
        r_c_side.a2    <= ((w_dy64 <<< 1) + w_dy64) - (w_hm0 <<< 1) - w_hm1;
        r_c_side.hm0   <= w_hm0;
        r_c_side.y0    <= w_hm0_side.y0;
        r_c_side.t     <= w_hm0_side.t;
        r_c_side.sat   <= w_hm0_sat || w_hm1_sat;
        r_c_side.ext   <= w_hm0_side.ext;
        r_c_side.hz    <= w_hm0_side.hz;
    end

    // First Horner step.
    chs_mulq #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(t_h1_side))
    ) u_h1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c_valid),
        .i_a     (r_c_a3),
        .i_b     (r_c_side.t),
        .i_side  (r_c_side),
        .o_valid (w_h1_valid),
        .o_p     (w_h1_p),
        .o_sat   (w_h1_sat),
        .o_side  (w_h1_side)
    );

    assign w_sum1 = 65'(w_h1_side.a2) + 65'(w_h1_p);

    always_ff @(posedge i_clk) begin
        logic sat;
        sat = 1'b0;
        if (w_sum1 > 65'(chs_pkg::SAT64)) begin
            r_a1_acc <= chs_pkg::SAT64;
            sat = 1'b1;
        end else if (w_sum1 < 65'(chs_pkg::NEG_SAT64)) begin
            r_a1_acc <= chs_pkg::NEG_SAT64;
            sat = 1'b1;
        end else begin
            r_a1_acc <= 64'(w_sum1);
        end
        r_a1_side.hm0 <= w_h1_side.hm0;
        r_a1_side.y0  <= w_h1_side.y0;
        r_a1_side.t   <= w_h1_side.t;
        r_a1_side.sat <= w_h1_side.sat || w_h1_sat || sat;
        r_a1_side.ext <= w_h1_side.ext;
        r_a1_side.hz  <= w_h1_side.hz;
    end

    // Second Horner step.
    chs_mulq #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(t_h2_side))
    ) u_h2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a1_valid),
        .i_a     (r_a1_acc),
        .i_b     (r_a1_side.t),
        .i_side  (r_a1_side),
        .o_valid (w_h2_valid),
        .o_p     (w_h2_p),
        .o_sat   (w_h2_sat),
        .o_side  (w_h2_side)
    );

    assign w_sum2 = 65'(w_h2_side.hm0) + 65'(w_h2_p);

    always_ff @(posedge i_clk) begin
        logic sat;
        sat = 1'b0;
        if (w_sum2 > 65'(chs_pkg::SAT64)) begin
            r_a2_acc <= chs_pkg::SAT64;
            sat = 1'b1;
        end else if (w_sum2 < 65'(chs_pkg::NEG_SAT64)) begin
            r_a2_acc <= chs_pkg::NEG_SAT64;
            sat = 1'b1;
        end else begin
            r_a2_acc <= 64'(w_sum2);
        end
        r_a2_side.y0  <= w_h2_side.y0;
        r_a2_side.sat <= w_h2_side.sat || w_h2_sat || sat;
        r_a2_side.ext <= w_h2_side.ext;
        r_a2_side.hz  <= w_h2_side.hz;
    end

    // Third Horner step; t rides on the second step's side band.
    chs_mulq #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(t_h3_side))
    ) u_h3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a2_valid),
        .i_a     (r_a2_acc),
        .i_b     (r_a2_t),
        .i_side  (r_a2_side),
        .o_valid (w_h3_valid),
        .o_p     (w_h3_p),
        .o_sat   (w_h3_sat),
        .o_side  (w_h3_side)
    );

    always_ff @(posedge i_clk) begin
        r_a2_t <= w_h2_side.t;
    end

    assign w_sum3 = 65'(w_h3_side.y0) + 65'(w_h3_p);

    always_ff @(posedge i_clk) begin
        logic sat;
        sat = 1'b0;
        if (w_sum3 > 65'(chs_pkg::SAT64)) begin
            r_a3_acc <= chs_pkg::SAT64;
            sat = 1'b1;
        end else if (w_sum3 < 65'(chs_pkg::NEG_SAT64)) begin
            r_a3_acc <= chs_pkg::NEG_SAT64;
            sat = 1'b1;
        end else begin
            r_a3_acc <= 64'(w_sum3);
        end
        r_a3_side.y0  <= w_h3_side.y0;
        r_a3_side.sat <= w_h3_side.sat || w_h3_sat || sat;
        r_a3_side.ext <= w_h3_side.ext;
        r_a3_side.hz  <= w_h3_side.hz;
    end

    // Final clamp and status.
    always_ff @(posedge i_clk) begin
        if (r_a3_side.hz) begin
            r_out_value  <= r_a3_side.y0;
            r_out_status <= chs_pkg::ST_ZERO;
        end else if (r_a3_acc > chs_pkg::WORD_MAX) begin
            r_out_value  <= 32'(chs_pkg::WORD_MAX);
            r_out_status <= chs_pkg::ST_SAT;
        end else if (r_a3_acc < chs_pkg::WORD_MIN) begin
            r_out_value  <= 32'(chs_pkg::WORD_MIN);
            r_out_status <= chs_pkg::ST_SAT;
        end else begin
            r_out_value <= 32'(r_a3_acc);
            if (r_a3_side.sat) begin
                r_out_status <= chs_pkg::ST_SAT;
            end else if (r_a3_side.ext) begin
                r_out_status <= chs_pkg::ST_EXTRAP;
            end else begin
                r_out_status <= chs_pkg::ST_INSIDE;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_curve_value = r_out_value;
    assign o_status      = r_out_status;

endmodule
